@@ rtl/interval_stall_allocator_assert.svh @@
// Assertion macros for the interval stall allocator checks.
`ifndef INTERVAL_STALL_ALLOCATOR_ASSERT_SVH
`define INTERVAL_STALL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define ISA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval stall allocator check failed");

// next-cycle implication
`define ISA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval stall allocator check failed");

`endif

@@ rtl/isa_pkg.sv @@
// Shared constants and types of the interval stall allocator.
`default_nettype none
package isa_pkg;
  localparam int MAX_INTERVALS = 1024;
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int TIME_BITS = 20;
  localparam int VALUE_W = 11;
  localparam int STATUS_W = 2;
  localparam int OPCODE_W = 2;
  localparam int INDEX_W = 11;

  localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_READ = 2'd2;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } run_ctl_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] total;
  } run_sts_t;
endpackage
`default_nettype wire

@@ rtl/interval_stall_allocator.sv @@
// Interval stall allocator top level: command decode, interval stores, result register.
//
//  channel | direction | beat contents
//  in_     | input     | opcode, interval_start, interval_end, read_index
//  out_    | output    | value, status
//
// Load, unused opcode and rejected read: result registered straight from the command decode.
// Accepted read: one stall memory read, then the result register.
// Run over n intervals: one step per interval; each step scans
// the start memory once and the per-stall end memory up to the first free stall.
// Reset clears all control state; no memory is cleared.
// A new beat is taken only once the previous result has been taken.
`default_nettype none
module interval_stall_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [isa_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [isa_pkg::TIME_BITS-1:0]   in_interval_start,
  input  wire logic [isa_pkg::TIME_BITS-1:0]   in_interval_end,
  input  wire logic [isa_pkg::INDEX_W-1:0]     in_read_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [isa_pkg::VALUE_W-1:0]          out_value,
  output logic [isa_pkg::STATUS_W-1:0]         out_status
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0]                     st_r, st_nxt;
  logic [isa_pkg::CNT_W-1:0]      loaded_r, loaded_nxt;
  logic [isa_pkg::CNT_W-1:0]      total_r, total_nxt;
  logic                           set_done_r, set_done_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [isa_pkg::VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [isa_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                           in_fire, ld_we;
  logic [isa_pkg::CNT_W-1:0]      ld_base;
  logic [isa_pkg::INDEX_W-1:0]    rd_idx_m1;
  logic                           sof_re;
  logic [isa_pkg::CNT_W-1:0]      sof_rdata;

  isa_pkg::run_ctl_t              run_ctl;
  isa_pkg::run_sts_t              run_sts;
  logic                           start_re, end_re, sof_we;
  logic [isa_pkg::IDX_W-1:0]      start_raddr, end_raddr, sof_waddr;
  logic [isa_pkg::TIME_BITS-1:0]  start_rdata, end_rdata;
  logic [isa_pkg::CNT_W-1:0]      sof_wdata;

  assign in_ready   = (st_r == S_IDLE) && !out_valid_r;
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign ld_base    = set_done_r ? '0 : loaded_r;
  assign rd_idx_m1  = isa_pkg::INDEX_W'(in_read_index - 1'b1);

  isa_ram #(.WIDTH(isa_pkg::TIME_BITS), .DEPTH(isa_pkg::MAX_INTERVALS)) u_start_mem (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_base[isa_pkg::IDX_W-1:0]),
    .wdata (in_interval_start),
    .re    (start_re),
    .raddr (start_raddr),
    .rdata (start_rdata)
  );

  isa_ram #(.WIDTH(isa_pkg::TIME_BITS), .DEPTH(isa_pkg::MAX_INTERVALS)) u_end_mem (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_base[isa_pkg::IDX_W-1:0]),
    .wdata (in_interval_end),
    .re    (end_re),
    .raddr (end_raddr),
    .rdata (end_rdata)
  );

  isa_ram #(.WIDTH(isa_pkg::CNT_W), .DEPTH(isa_pkg::MAX_INTERVALS)) u_stall_of_mem (
    .clk   (clk),
    .we    (sof_we),
    .waddr (sof_waddr),
    .wdata (sof_wdata),
    .re    (sof_re),
    .raddr (rd_idx_m1[isa_pkg::IDX_W-1:0]),
    .rdata (sof_rdata)
  );

  isa_run u_run (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (run_ctl),
    .sts         (run_sts),
    .start_re    (start_re),
    .start_raddr (start_raddr),
    .start_rdata (start_rdata),
    .end_re      (end_re),
    .end_raddr   (end_raddr),
    .end_rdata   (end_rdata),
    .sof_we      (sof_we),
    .sof_waddr   (sof_waddr),
    .sof_wdata   (sof_wdata)
  );

  always_comb begin
    st_nxt         = st_r;
    loaded_nxt     = loaded_r;
    total_nxt      = total_r;
    set_done_nxt   = set_done_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ld_we          = 1'b0;
    sof_re         = 1'b0;
    run_ctl.start  = 1'b0;
    run_ctl.count  = loaded_r;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            isa_pkg::OP_LOAD: begin
              out_valid_nxt = 1'b1;
              if (set_done_r) begin
                total_nxt    = '0;
                set_done_nxt = 1'b0;
              end
              if (ld_base == isa_pkg::CNT_W'(isa_pkg::MAX_INTERVALS)) begin
                loaded_nxt     = ld_base;
                out_value_nxt  = isa_pkg::VALUE_W'(ld_base);
                out_status_nxt = isa_pkg::ST_FULL;
              end else begin
                ld_we          = 1'b1;
                loaded_nxt     = isa_pkg::CNT_W'(ld_base + 1'b1);
                out_value_nxt  = isa_pkg::VALUE_W'(ld_base + 1'b1);
                out_status_nxt = isa_pkg::ST_OK;
              end
            end
            isa_pkg::OP_RUN: begin
              if (loaded_r == '0) begin
                total_nxt      = '0;
                set_done_nxt   = 1'b1;
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = isa_pkg::ST_OK;
              end else begin
                run_ctl.start = 1'b1;
                st_nxt        = S_RUN;
              end
            end
            isa_pkg::OP_READ: begin
              if (!set_done_r || (in_read_index == '0) ||
                  (in_read_index > isa_pkg::INDEX_W'(loaded_r))) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = isa_pkg::ST_BAD_READ;
              end else begin
                sof_re = 1'b1;
                st_nxt = S_READ;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = isa_pkg::ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = isa_pkg::VALUE_W'(sof_rdata);
        out_status_nxt = isa_pkg::ST_OK;
        st_nxt         = S_IDLE;
      end
      S_RUN: begin
        if (run_sts.done) begin
          total_nxt      = run_sts.total;
          set_done_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = isa_pkg::VALUE_W'(run_sts.total);
          out_status_nxt = isa_pkg::ST_OK;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      loaded_r    <= '0;
      total_r     <= '0;
      set_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      loaded_r    <= loaded_nxt;
      total_r     <= total_nxt;
      set_done_r  <= set_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end
endmodule
`default_nettype wire

@@ rtl/isa_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module isa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/isa_run.sv @@
// Allocation sequencer: ordered selection scan, free stall search, write back.
`default_nettype none
module isa_run (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire isa_pkg::run_ctl_t              ctl,
  output isa_pkg::run_sts_t                   sts,
  output logic                                start_re,
  output logic [isa_pkg::IDX_W-1:0]           start_raddr,
  input  wire logic [isa_pkg::TIME_BITS-1:0]  start_rdata,
  output logic                                end_re,
  output logic [isa_pkg::IDX_W-1:0]           end_raddr,
  input  wire logic [isa_pkg::TIME_BITS-1:0]  end_rdata,
  output logic                                sof_we,
  output logic [isa_pkg::IDX_W-1:0]           sof_waddr,
  output logic [isa_pkg::CNT_W-1:0]           sof_wdata
);
  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_SEL   = 3'd1;
  localparam logic [2:0] E_FETCH = 3'd2;
  localparam logic [2:0] E_FIND  = 3'd3;
  localparam logic [2:0] E_WRITE = 3'd4;
  localparam logic [2:0] E_DONE  = 3'd5;

  logic [2:0]                      st_r, st_nxt;
  logic [isa_pkg::CNT_W-1:0]       n_r, n_nxt;
  logic [isa_pkg::CNT_W-1:0]       sa_r, sa_nxt;
  logic                            pv_r, pv_nxt;
  logic [isa_pkg::IDX_W-1:0]       pidx_r, pidx_nxt;
  logic                            have_prev_r, have_prev_nxt;
  logic [isa_pkg::TIME_BITS-1:0]   prev_s_r, prev_s_nxt;
  logic [isa_pkg::IDX_W-1:0]       prev_idx_r, prev_idx_nxt;
  logic                            best_v_r, best_v_nxt;
  logic [isa_pkg::TIME_BITS-1:0]   best_s_r, best_s_nxt;
  logic [isa_pkg::IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [isa_pkg::CNT_W-1:0]       fa_r, fa_nxt;
  logic                            fv_r, fv_nxt;
  logic [isa_pkg::IDX_W-1:0]       fidx_r, fidx_nxt;
  logic [isa_pkg::CNT_W-1:0]       stall_r, stall_nxt;
  logic [isa_pkg::CNT_W-1:0]       total_r, total_nxt;
  logic [isa_pkg::CNT_W-1:0]       done_cnt_r, done_cnt_nxt;

  logic                            se_re, se_we;
  logic [isa_pkg::TIME_BITS-1:0]   se_rdata;
  logic [isa_pkg::CNT_W-1:0]       stall_m1;
  logic                            cand_after, cand_better;

  assign stall_m1 = isa_pkg::CNT_W'(stall_r - 1'b1);

  isa_ram #(.WIDTH(isa_pkg::TIME_BITS), .DEPTH(isa_pkg::MAX_INTERVALS)) u_stall_end (
    .clk   (clk),
    .we    (se_we),
    .waddr (stall_m1[isa_pkg::IDX_W-1:0]),
    .wdata (end_rdata),
    .re    (se_re),
    .raddr (fa_r[isa_pkg::IDX_W-1:0]),
    .rdata (se_rdata)
  );

  assign cand_after = !have_prev_r || (start_rdata > prev_s_r) ||
                      ((start_rdata == prev_s_r) && (pidx_r > prev_idx_r));
  assign cand_better = !best_v_r || (start_rdata < best_s_r) ||
                       ((start_rdata == best_s_r) && (pidx_r < best_idx_r));

  assign start_raddr = sa_r[isa_pkg::IDX_W-1:0];
  assign end_raddr   = best_idx_r;
  assign sof_waddr   = best_idx_r;
  assign sof_wdata   = stall_r;

  always_comb begin
    st_nxt        = st_r;
    n_nxt         = n_r;
    sa_nxt        = sa_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    have_prev_nxt = have_prev_r;
    prev_s_nxt    = prev_s_r;
    prev_idx_nxt  = prev_idx_r;
    best_v_nxt    = best_v_r;
    best_s_nxt    = best_s_r;
    best_idx_nxt  = best_idx_r;
    fa_nxt        = fa_r;
    fv_nxt        = 1'b0;
    fidx_nxt      = fidx_r;
    stall_nxt     = stall_r;
    total_nxt     = total_r;
    done_cnt_nxt  = done_cnt_r;
    start_re      = 1'b0;
    end_re        = 1'b0;
    se_re         = 1'b0;
    se_we         = 1'b0;
    sof_we        = 1'b0;
    sts.done      = 1'b0;
    sts.total     = total_r;
    case (st_r)
      E_IDLE: begin
        if (ctl.start) begin
          n_nxt         = ctl.count;
          total_nxt     = '0;
          have_prev_nxt = 1'b0;
          done_cnt_nxt  = '0;
          sa_nxt        = '0;
          best_v_nxt    = 1'b0;
          st_nxt        = E_SEL;
        end
      end
      E_SEL: begin
        if (pv_r && cand_after && cand_better) begin
          best_v_nxt   = 1'b1;
          best_s_nxt   = start_rdata;
          best_idx_nxt = pidx_r;
        end
        if (sa_r == n_r) begin
          st_nxt = E_FETCH;
        end else begin
          start_re = 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = sa_r[isa_pkg::IDX_W-1:0];
          sa_nxt   = isa_pkg::CNT_W'(sa_r + 1'b1);
        end
      end
      E_FETCH: begin
        end_re        = 1'b1;
        have_prev_nxt = 1'b1;
        prev_s_nxt    = best_s_r;
        prev_idx_nxt  = best_idx_r;
        fa_nxt        = '0;
        st_nxt        = E_FIND;
      end
      E_FIND: begin
        if (fv_r && (se_rdata < best_s_r)) begin
          stall_nxt = isa_pkg::CNT_W'({1'b0, fidx_r} + 1'b1);
          st_nxt    = E_WRITE;
        end else if (fa_r == total_r) begin
          stall_nxt = isa_pkg::CNT_W'(total_r + 1'b1);
          total_nxt = isa_pkg::CNT_W'(total_r + 1'b1);
          st_nxt    = E_WRITE;
        end else begin
          se_re    = 1'b1;
          fv_nxt   = 1'b1;
          fidx_nxt = fa_r[isa_pkg::IDX_W-1:0];
          fa_nxt   = isa_pkg::CNT_W'(fa_r + 1'b1);
        end
      end
      E_WRITE: begin
        sof_we       = 1'b1;
        se_we        = 1'b1;
        done_cnt_nxt = isa_pkg::CNT_W'(done_cnt_r + 1'b1);
        if (isa_pkg::CNT_W'(done_cnt_r + 1'b1) == n_r) begin
          st_nxt = E_DONE;
        end else begin
          sa_nxt     = '0;
          best_v_nxt = 1'b0;
          st_nxt     = E_SEL;
        end
      end
      E_DONE: begin
        sts.done = 1'b1;
        st_nxt   = E_IDLE;
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
      pv_r <= 1'b0;
      fv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pv_r <= pv_nxt;
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    sa_r        <= sa_nxt;
    pidx_r      <= pidx_nxt;
    have_prev_r <= have_prev_nxt;
    prev_s_r    <= prev_s_nxt;
    prev_idx_r  <= prev_idx_nxt;
    best_v_r    <= best_v_nxt;
    best_s_r    <= best_s_nxt;
    best_idx_r  <= best_idx_nxt;
    fa_r        <= fa_nxt;
    fidx_r      <= fidx_nxt;
    stall_r     <= stall_nxt;
    total_r     <= total_nxt;
    done_cnt_r  <= done_cnt_nxt;
  end
endmodule
`default_nettype wire

@@ rtl/isa_checker.sv @@
// Port-level checks for the interval stall allocator and their bind.
`default_nettype none
`include "interval_stall_allocator_assert.svh"
module isa_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [isa_pkg::VALUE_W-1:0]     out_value,
  input wire logic [isa_pkg::STATUS_W-1:0]    out_status
);
  `ISA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status))
  `ISA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `ISA_ASSERT_IMP(a_bad_read_zero, out_valid && (out_status == isa_pkg::ST_BAD_READ), out_value == '0)
  `ISA_ASSERT_IMP(a_full_count, out_valid && (out_status == isa_pkg::ST_FULL), out_value == isa_pkg::VALUE_W'(isa_pkg::MAX_INTERVALS))
endmodule

bind interval_stall_allocator isa_checker u_isa_checker (.*);
`default_nettype wire

@@ tb/tb_interval_stall_allocator.sv @@
// Self-checking testbench for the interval stall allocator: loads, runs, reads under stalls.
`timescale 1ns / 1ps
`default_nettype none
module tb_interval_stall_allocator;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [isa_pkg::OPCODE_W-1:0] in_opcode = isa_pkg::OP_LOAD;
  logic [isa_pkg::TIME_BITS-1:0] in_interval_start = '0;
  logic [isa_pkg::TIME_BITS-1:0] in_interval_end = '0;
  logic [isa_pkg::INDEX_W-1:0] in_read_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [isa_pkg::VALUE_W-1:0] out_value;
  logic [isa_pkg::STATUS_W-1:0] out_status;

  localparam logic [isa_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

  interval_stall_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_interval_start(in_interval_start),
    .in_interval_end(in_interval_end), .in_read_index(in_read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [isa_pkg::VALUE_W-1:0] value;
    logic [isa_pkg::STATUS_W-1:0] status;
  } answer_t;

  // allocator mirror
  logic [isa_pkg::TIME_BITS-1:0] iv_start [isa_pkg::MAX_INTERVALS];
  logic [isa_pkg::TIME_BITS-1:0] iv_end [isa_pkg::MAX_INTERVALS];
  int unsigned stall_of [isa_pkg::MAX_INTERVALS];
  int unsigned n_loaded = 0;
  int unsigned n_stalls = 0;
  bit set_closed = 1'b0;

  answer_t answers_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned beats_out = 0;
  int unsigned n_runs = 0;

  task automatic allocate_stalls();
    int unsigned order [$];
    int unsigned busy_stall [$];
    int unsigned busy_end [$];
    int unsigned free_list [$];
    int unsigned id, j, k;
    order = {};
    for (int unsigned i = 0; i < n_loaded; i++) order.push_back(i);
    order.sort() with ({iv_start[item], item[10:0]});
    n_stalls = 0;
    foreach (order[o]) begin
      id = order[o];
      j = 0;
      while (j < busy_end.size()) begin
        if (busy_end[j] < iv_start[id]) begin
          free_list.push_back(busy_stall[j]);
          busy_end.delete(j);
          busy_stall.delete(j);
        end else begin
          j++;
        end
      end
      if (free_list.size() == 0) begin
        n_stalls++;
        free_list.push_back(n_stalls);
      end
      k = 0;
      for (int unsigned m = 1; m < free_list.size(); m++)
        if (free_list[m] < free_list[k]) k = m;
      stall_of[id] = free_list[k];
      free_list.delete(k);
      busy_end.push_back(iv_end[id]);
      busy_stall.push_back(stall_of[id]);
    end
    set_closed = 1'b1;
  endtask

  task automatic predict_answer(input logic [isa_pkg::OPCODE_W-1:0] op,
                                input logic [isa_pkg::TIME_BITS-1:0] s,
                                input logic [isa_pkg::TIME_BITS-1:0] e,
                                input logic [isa_pkg::INDEX_W-1:0] ri);
    answer_t a;
    a = '{value: '0, status: isa_pkg::ST_OK};
    case (op)
      isa_pkg::OP_LOAD: begin
        if (set_closed) begin
          n_loaded = 0;
          n_stalls = 0;
          set_closed = 1'b0;
        end
        if (n_loaded >= isa_pkg::MAX_INTERVALS) begin
          a.status = isa_pkg::ST_FULL;
        end else begin
          iv_start[n_loaded] = s;
          iv_end[n_loaded] = e;
          n_loaded++;
        end
        a.value = n_loaded[isa_pkg::VALUE_W-1:0];
      end
      isa_pkg::OP_RUN: begin
        allocate_stalls();
        n_runs++;
        a.value = n_stalls[isa_pkg::VALUE_W-1:0];
      end
      isa_pkg::OP_READ: begin
        if (!set_closed || ri == 0 || ri > n_loaded) a.status = isa_pkg::ST_BAD_READ;
        else a.value = stall_of[ri-1][isa_pkg::VALUE_W-1:0];
      end
      default: ;
    endcase
    answers_due.push_back(a);
  endtask

  task automatic send_beat(input logic [isa_pkg::OPCODE_W-1:0] op,
                           input logic [isa_pkg::TIME_BITS-1:0] s,
                           input logic [isa_pkg::TIME_BITS-1:0] e,
                           input logic [isa_pkg::INDEX_W-1:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_interval_start <= s;
    in_interval_end <= e;
    in_read_index <= ri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_answer(op, s, e, ri);
  endtask

  task automatic load(input logic [isa_pkg::TIME_BITS-1:0] s,
                      input logic [isa_pkg::TIME_BITS-1:0] e);
    send_beat(isa_pkg::OP_LOAD, s, e, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat value=%0d status=%0d", out_value, out_status);
      end else begin
        answer_t a;
        a = answers_due.pop_front();
        if (a.value !== out_value || a.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value=%0d status=%0d, got value=%0d status=%0d",
                     a.value, a.status, out_value, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_beat(isa_pkg::OP_RUN, '0, '0, '0);
    send_beat(isa_pkg::OP_READ, '0, '0, 11'd1);
    load(20'd10, 20'd20);
    load(20'd0, 20'hFFFFF);
    load(20'd10, 20'd15);
    load(20'd20, 20'd30);
    load(20'd16, 20'd16);
    load(20'hFFFFF, 20'hFFFFF);
    send_beat(isa_pkg::OP_READ, '0, '0, 11'd1);
    send_beat(isa_pkg::OP_RUN, '0, '0, '0);
    send_beat(isa_pkg::OP_RUN, '0, '0, '0);
    for (int i = 0; i <= 7; i++) send_beat(isa_pkg::OP_READ, '0, '0, i[isa_pkg::INDEX_W-1:0]);
    send_beat(isa_pkg::OP_READ, '0, '0, 11'h7FF);
    send_beat(OP_SPARE, 20'hFFFFF, 20'hFFFFF, 11'h7FF);
    load(20'd5, 20'd4);
    send_beat(isa_pkg::OP_READ, '0, '0, 11'd1);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < isa_pkg::MAX_INTERVALS + 2; i++)
      load(20'($urandom_range(3000)), 20'($urandom_range(3000)));
    send_beat(isa_pkg::OP_RUN, '0, '0, '0);
    send_beat(isa_pkg::OP_READ, '0, '0, 11'd1024);
    send_beat(isa_pkg::OP_READ, '0, '0, 11'd1025);
    drain();
  endtask

  task automatic random_set(input int unsigned span);
    int unsigned n;
    logic [isa_pkg::TIME_BITS-1:0] s;
    n = $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      s = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(span));
      load(s, ($urandom_range(9) == 0) ? 20'($urandom) : s + 20'($urandom_range(span)));
    end
    if ($urandom_range(9) != 0) send_beat(isa_pkg::OP_RUN, '0, '0, '0);
    repeat ($urandom_range(1, 6))
      send_beat(($urandom_range(15) == 0) ? OP_SPARE : isa_pkg::OP_READ, '0, '0,
                11'($urandom_range(n + 1)));
    if ($urandom_range(19) == 0) send_beat(isa_pkg::OP_READ, '0, '0, 11'($urandom));
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned target;
    target = beats_out + answers_due.size() + n_items;
    while (beats_out + answers_due.size() < target) random_set($urandom_range(4, 60));
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 10; i++) load(20'($urandom_range(50)), 20'($urandom_range(50, 90)));
    send_beat(isa_pkg::OP_RUN, '0, '0, '0);
    drain();
    for (int i = 1; i <= 10; i++) send_beat(isa_pkg::OP_READ, '0, '0, i[isa_pkg::INDEX_W-1:0]);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_backpressure();
    test_random(110);
    send_idle_pct = 69;
    test_random(110);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    test_random(110);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    test_random(110);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_store_full();
    drain();
    $display("Covered %0d result beats over %0d allocation runs, incl. full store and stalls.",
             beats_out, n_runs);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/isa_pkg.sv
rtl/isa_ram.sv
rtl/isa_run.sv
rtl/interval_stall_allocator.sv
rtl/isa_checker.sv
tb/tb_interval_stall_allocator.sv
